// ----- rtl/dqcv_pkg.sv -----
package dqcv_pkg;

    // Field widths fixed by the item format.
    localparam int COUNT_W   = 32;
    localparam int GAIN_W    = 32;
    localparam int PERIOD_W  = 16;
    localparam int PROD_W    = 64;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 128;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd20;

    // Action codes carried in s_tuser.
    typedef enum logic [1:0] {
        ACT_PIN   = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_SET   = 2'd2,
        ACT_RESET = 2'd3
    } action_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LEFT_INVERT  = 2'd0,
        CFG_RIGHT_INVERT = 2'd1,
        CFG_PERIOD_MS    = 2'd2,
        CFG_VEL_GAIN     = 2'd3
    } cfg_index_t;

    // Control shared by both lanes for the accepted transaction.
    typedef struct packed {
        logic    acc;
        action_t action;
        logic    tick_fire;
        logic    en1;
    } lane_ctrl_t;

    // What a lane hands to the merging stage.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [PROD_W-1:0]  product;
    } lane_res_t;

    // Control of the output stage.
    typedef struct packed {
        logic v1;
        logic upd1;
        logic clr1;
        logic en2;
    } merge_ctrl_t;

endpackage

// ----- rtl/dqcv_lane.sv -----
module dqcv_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dqcv_pkg::lane_ctrl_t          ctrl,
    input  logic                          pin_a,
    input  logic                          pin_b,
    input  logic                          set_sel,
    input  logic                          invert,
    input  logic [dqcv_pkg::COUNT_W-1:0]  set_value,
    input  logic [dqcv_pkg::GAIN_W-1:0]   gain,
    output dqcv_pkg::lane_res_t           res
);
    import dqcv_pkg::*;

    logic [COUNT_W-1:0]        count_reg, count_next;
    logic [COUNT_W-1:0]        start_reg, start_next;
    logic                      prev_a_reg, prev_a_next;
    logic [COUNT_W-1:0]        count0_reg;
    logic signed [COUNT_W-1:0] delta0_reg;
    logic [COUNT_W-1:0]        count1_reg;
    logic [PROD_W-1:0]         prod1_reg;
    logic signed [GAIN_W:0]    gain_s;
    logic signed [COUNT_W+GAIN_W:0] prod_full;
    logic                      step_up;

    // Direction of one quadrature step.
    assign step_up = (pin_a != pin_b) ^ invert;

    // Count and window state after the accepted transaction.
    always_comb begin
        count_next  = count_reg;
        start_next  = start_reg;
        prev_a_next = prev_a_reg;
        if (ctrl.acc) begin
            unique case (ctrl.action)
                ACT_PIN: begin
                    if (pin_a != prev_a_reg) begin
                        count_next = step_up ? count_reg + 1'b1 : count_reg - 1'b1;
                    end
                    prev_a_next = pin_a;
                end
                ACT_TICK: begin
                    if (ctrl.tick_fire) begin
                        start_next = count_reg;
                    end
                end
                ACT_SET: begin
                    if (set_sel) begin
                        count_next = set_value;
                        start_next = set_value;
                    end
                end
                ACT_RESET: begin
                    count_next = '0;
                    start_next = '0;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            start_reg  <= '0;
            prev_a_reg <= 1'b1;
        end else begin
            count_reg  <= count_next;
            start_reg  <= start_next;
            prev_a_reg <= prev_a_next;
        end
    end

    // Stage 0: count after the item and the window delta.
    always_ff @(posedge aclk) begin
        if (ctrl.acc) begin
            count0_reg <= count_next;
            delta0_reg <= count_reg - start_reg;
        end
    end

    // Stage 1: signed delta times unsigned Q16.16 gain.
    assign gain_s    = {1'b0, gain};
    assign prod_full = delta0_reg * gain_s;

    always_ff @(posedge aclk) begin
        if (ctrl.en1) begin
            count1_reg <= count0_reg;
            prod1_reg  <= prod_full[PROD_W-1:0];
        end
    end

    assign res.count   = count1_reg;
    assign res.product = prod1_reg;

endmodule

// ----- rtl/dqcv_merge.sv -----
module dqcv_merge (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dqcv_pkg::merge_ctrl_t          ctrl,
    input  dqcv_pkg::lane_res_t            left_res,
    input  dqcv_pkg::lane_res_t            right_res,
    output logic                           m_tvalid,
    output logic [dqcv_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser
);
    import dqcv_pkg::*;

    logic [COUNT_W-1:0] left_speed_reg, right_speed_reg;
    logic [COUNT_W-1:0] left_count_reg, right_count_reg;
    logic               valid_reg, updated_reg;
    logic [COUNT_W-1:0] left_vel, right_vel;

    // Saturate a 64-bit product to the signed 32-bit range.
    function automatic logic [COUNT_W-1:0] sat32(input logic [PROD_W-1:0] p);
        logic hi, lo;
        hi = !p[PROD_W-1] && (|p[PROD_W-2:COUNT_W-1]);
        lo = p[PROD_W-1] && !(&p[PROD_W-2:COUNT_W-1]);
        if (hi) begin
            sat32 = {1'b0, {(COUNT_W-1){1'b1}}};
        end else if (lo) begin
            sat32 = {1'b1, {(COUNT_W-1){1'b0}}};
        end else begin
            sat32 = p[COUNT_W-1:0];
        end
    endfunction

    assign left_vel  = sat32(left_res.product);
    assign right_vel = sat32(right_res.product);

    // Velocities are held here and change in item order.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            left_speed_reg  <= '0;
            right_speed_reg <= '0;
        end else if (ctrl.en2) begin
            valid_reg <= ctrl.v1;
            if (ctrl.v1 && ctrl.upd1) begin
                left_speed_reg  <= left_vel;
                right_speed_reg <= right_vel;
            end else if (ctrl.v1 && ctrl.clr1) begin
                left_speed_reg  <= '0;
                right_speed_reg <= '0;
            end
        end
    end

    // Output register for counts and the update flag.
    always_ff @(posedge aclk) begin
        if (ctrl.en2) begin
            left_count_reg  <= left_res.count;
            right_count_reg <= right_res.count;
            updated_reg     <= ctrl.upd1;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {right_speed_reg, left_speed_reg, right_count_reg, left_count_reg};
    assign m_tuser  = updated_reg;

endmodule

// ----- rtl/dual_quadrature_counter_velocity.sv -----
// Channel  Direction  Ports                                Contents
// s_       in         s_tvalid s_tready s_tdata s_tuser    one action with pin levels
// m_       out        m_tvalid m_tready m_tdata m_tuser    counts, velocities, update flag
// cfg_     in         cfg_valid cfg_ready cfg_index cfg_data   register writes
//
// One transaction is accepted per clock while s_tready is high; its result is
// registered in stage 0, stage 1 and the output stage. Counts and the window
// counter update in the accept cycle, so back-to-back items see each other. The
// velocity multiply is one stage per lane, saturation and the velocity registers
// sit in the output stage. Reset is synchronous; no clearing pass is needed.
// s_tready drops only when all three stages hold results and m_tready is low.
module dual_quadrature_counter_velocity (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // left_a, left_b, right_a, right_b, side, set_value[31:0], zero fill
    input  logic [dqcv_pkg::S_TDATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // left_count, right_count, left_velocity, right_velocity
    output logic [dqcv_pkg::M_TDATA_W-1:0]  m_tdata,
    // velocity_updated
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  dqcv_pkg::cfg_index_t            cfg_index,
    input  logic [dqcv_pkg::GAIN_W-1:0]     cfg_data
);
    import dqcv_pkg::*;

    logic                left_invert_reg, right_invert_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [PERIOD_W-1:0] elapsed_reg, elapsed_next;
    logic [PERIOD_W:0]   elapsed_inc;
    logic                v0_reg, v1_reg, upd0_reg, clr0_reg, upd1_reg, clr1_reg;
    logic                en0, en1, en2, acc, tick_fire;
    action_t             action;
    lane_ctrl_t          lctrl;
    merge_ctrl_t         mctrl;
    lane_res_t           left_res, right_res;

    // Configuration writes are taken every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_invert_reg  <= 1'b0;
            right_invert_reg <= 1'b0;
            period_reg       <= PERIOD_RESET;
            gain_reg         <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LEFT_INVERT:  left_invert_reg  <= cfg_data[0];
                CFG_RIGHT_INVERT: right_invert_reg <= cfg_data[0];
                CFG_PERIOD_MS:    period_reg       <= cfg_data[PERIOD_W-1:0];
                CFG_VEL_GAIN:     gain_reg         <= cfg_data;
                default:          gain_reg         <= gain_reg;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or the next one loads.
    assign en2      = !m_tvalid || m_tready;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign s_tready = en0;
    assign acc      = s_tvalid && s_tready;
    assign action   = action_t'(s_tuser);

    // Millisecond window; a zero period fires on every tick.
    assign elapsed_inc = {1'b0, elapsed_reg} + 1'b1;
    assign tick_fire   = elapsed_inc >= {1'b0, period_reg};

    always_comb begin
        elapsed_next = elapsed_reg;
        if (acc) begin
            unique case (action)
                ACT_TICK:  elapsed_next = tick_fire ? '0 : elapsed_inc[PERIOD_W-1:0];
                ACT_RESET: elapsed_next = '0;
                default:   elapsed_next = elapsed_reg;
            endcase
        end
    end

    // Stage valids and per-item flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg <= '0;
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
        end else begin
            elapsed_reg <= elapsed_next;
            if (en0) begin
                v0_reg <= s_tvalid;
            end
            if (en1) begin
                v1_reg <= v0_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en0) begin
            upd0_reg <= (action == ACT_TICK) && tick_fire;
            clr0_reg <= (action == ACT_RESET);
        end
        if (en1) begin
            upd1_reg <= upd0_reg;
            clr1_reg <= clr0_reg;
        end
    end

    assign lctrl.acc       = acc;
    assign lctrl.action    = action;
    assign lctrl.tick_fire = tick_fire;
    assign lctrl.en1       = en1;

    dqcv_lane u_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (lctrl),
        .pin_a     (s_tdata[0]),
        .pin_b     (s_tdata[1]),
        .set_sel   (!s_tdata[4]),
        .invert    (left_invert_reg),
        .set_value (s_tdata[36:5]),
        .gain      (gain_reg),
        .res       (left_res)
    );

    dqcv_lane u_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (lctrl),
        .pin_a     (s_tdata[2]),
        .pin_b     (s_tdata[3]),
        .set_sel   (s_tdata[4]),
        .invert    (right_invert_reg),
        .set_value (s_tdata[36:5]),
        .gain      (gain_reg),
        .res       (right_res)
    );

    assign mctrl.v1   = v1_reg;
    assign mctrl.upd1 = upd1_reg;
    assign mctrl.clr1 = clr1_reg;
    assign mctrl.en2  = en2;

    dqcv_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (mctrl),
        .left_res  (left_res),
        .right_res (right_res),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- rtl/dqcv_checker.sv -----
module dqcv_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [1:0]   cfg_index,
    input logic [31:0]  cfg_data
);
    import dqcv_pkg::*;

    logic [31:0] gain_seen_reg;
    logic [31:0] left_vel_reg, right_vel_reg;
    logic        cfg_gain_wr;

    assign cfg_gain_wr = cfg_valid && cfg_ready && (cfg_index == CFG_VEL_GAIN);

    // Track the gain register and the last delivered velocities.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_seen_reg <= '0;
            left_vel_reg  <= '0;
            right_vel_reg <= '0;
        end else begin
            if (cfg_gain_wr) begin
                gain_seen_reg <= cfg_data;
            end
            if (m_tvalid && m_tready) begin
                left_vel_reg  <= m_tdata[95:64];
                right_vel_reg <= m_tdata[127:96];
            end
        end
    end

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // With the output stage empty the input side always takes a transaction.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Velocities only change on an update or are cleared by a reset action.
    a_vel_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            (m_tdata[95:64] == left_vel_reg && m_tdata[127:96] == right_vel_reg) ||
            (m_tdata[95:64] == 32'd0 && m_tdata[127:96] == 32'd0))
        else $error("velocity changed without update");

    // A zero gain gives zero velocities.
    a_zero_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && gain_seen_reg == 32'd0 |->
            m_tdata[95:64] == 32'd0 && m_tdata[127:96] == 32'd0)
        else $error("nonzero velocity with zero gain");

endmodule

bind dual_quadrature_counter_velocity dqcv_checker u_dqcv_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import dqcv_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int MAX_GAP     = 18;
    localparam int LONG_HOLD   = 150;
    localparam int DRAIN_EXTRA = 8;

    // One pending input transaction with its lead-in gap.
    typedef struct {
        action_t              act;
        logic [S_TDATA_W-1:0] data;
        int                   gap;
    } enc_item_t;

    // One result as the block reports it.
    typedef struct {
        logic [31:0] left_count;
        logic [31:0] right_count;
        logic [31:0] left_vel;
        logic [31:0] right_vel;
        logic        updated;
    } odometry_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_index_t           cfg_index = CFG_LEFT_INVERT;
    logic [GAIN_W-1:0]    cfg_data = '0;

    dual_quadrature_counter_velocity u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Stimulus and scoreboard storage.
    enc_item_t pending_items[$];
    odometry_t expected_odometry[$];
    int        errors = 0;

    // Handshake flags seen at the last rising edge.
    logic item_fire = 1'b0;
    logic res_fire = 1'b0;

    // Traffic shaping shared by sender and receiver.
    bit idle_on = 1'b1;
    int hold_req = 0;
    int hold_seen = 0;
    int rx_wait = 0;

    // Driver bookkeeping.
    enc_item_t cur_item;
    bit        have_cur = 1'b0;
    int        gap_left = 0;

    // Predictor copy of the registers.
    bit          inv_left = 1'b0;
    bit          inv_right = 1'b0;
    bit [15:0]   win_period = PERIOD_RESET;
    bit [31:0]   vel_gain = '0;

    // Predictor copy of the decoder state.
    bit [31:0]   cnt_left = '0;
    bit [31:0]   cnt_right = '0;
    bit [31:0]   win_start_left = '0;
    bit [31:0]   win_start_right = '0;
    bit          prev_a_left = 1'b1;
    bit          prev_a_right = 1'b1;
    int unsigned elapsed_ticks = 0;
    bit [31:0]   vel_left = '0;
    bit [31:0]   vel_right = '0;

    // Random walk position of each encoder in its Gray cycle.
    int l_phase = 0;
    int r_phase = 0;
    int l_dir = 1;
    int r_dir = -1;

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // One quadrature step: up when A differs from B, flipped by the invert bit.
    function automatic bit [31:0] step_count(bit [31:0] cnt, bit a, bit b, bit inv);
        bit up;
        up = (a != b) ^ inv;
        return up ? cnt + 32'd1 : cnt - 32'd1;
    endfunction

    // Window delta times the Q16.16 gain, saturated to signed 32 bits.
    function automatic bit [31:0] window_velocity(bit [31:0] now_cnt, bit [31:0] start_cnt);
        bit [31:0] diff;
        longint    prod;
        diff = now_cnt - start_cnt;
        prod = longint'($signed(diff)) * longint'({32'd0, vel_gain});
        if (prod > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (prod < -64'sd2147483648)
            return 32'h8000_0000;
        return prod[31:0];
    endfunction

    // Apply one accepted transaction to the predictor and return its result.
    function automatic odometry_t advance_odometry(action_t act, logic [S_TDATA_W-1:0] d);
        odometry_t   r;
        bit          la;
        bit          lb;
        bit          ra;
        bit          rb;
        bit          side;
        bit [31:0]   setv;
        int unsigned next_ticks;
        la = d[0];
        lb = d[1];
        ra = d[2];
        rb = d[3];
        side = d[4];
        setv = d[36:5];
        r.updated = 1'b0;
        case (act)
            ACT_PIN: begin
                if (la != prev_a_left)
                    cnt_left = step_count(cnt_left, la, lb, inv_left);
                if (ra != prev_a_right)
                    cnt_right = step_count(cnt_right, ra, rb, inv_right);
                prev_a_left = la;
                prev_a_right = ra;
            end
            ACT_TICK: begin
                next_ticks = elapsed_ticks + 1;
                if (next_ticks >= win_period) begin
                    vel_left = window_velocity(cnt_left, win_start_left);
                    vel_right = window_velocity(cnt_right, win_start_right);
                    win_start_left = cnt_left;
                    win_start_right = cnt_right;
                    elapsed_ticks = 0;
                    r.updated = 1'b1;
                end else begin
                    elapsed_ticks = next_ticks & 16'hFFFF;
                end
            end
            ACT_SET: begin
                if (side == 1'b0) begin
                    cnt_left = setv;
                    win_start_left = setv;
                end else begin
                    cnt_right = setv;
                    win_start_right = setv;
                end
            end
            default: begin
                cnt_left = '0;
                cnt_right = '0;
                win_start_left = '0;
                win_start_right = '0;
                vel_left = '0;
                vel_right = '0;
                elapsed_ticks = 0;
            end
        endcase
        r.left_count = cnt_left;
        r.right_count = cnt_right;
        r.left_vel = vel_left;
        r.right_vel = vel_right;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d (0x%08h), actual %0d (0x%08h)",
                   name, $signed(want), want, $signed(got), got);
            errors++;
        end
    endfunction

    // Gray code levels for a phase: bit 1 is channel A, bit 0 is channel B.
    function automatic bit [1:0] gray_ab(int p);
        case (p & 3)
            0:       return 2'b00;
            1:       return 2'b10;
            2:       return 2'b11;
            default: return 2'b01;
        endcase
    endfunction

    // Queue one transaction; its lead-in gap follows the current idling mode.
    task automatic push_item(action_t act, bit la, bit lb, bit ra, bit rb, bit side,
                             bit [31:0] setv);
        enc_item_t it;
        it.act = act;
        it.data = {3'b000, setv, side, rb, ra, lb, la};
        it.gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        pending_items.push_back(it);
    endtask

    // Move one encoder along its Gray cycle, with the odd reversal or glitch.
    task automatic move_side(inout int ph, inout int dir, output bit a, output bit b);
        int        r;
        bit [1:0]  lv;
        r = $urandom_range(0, 9);
        if (r == 0)
            dir = -dir;
        if (r <= 6)
            ph = (ph + 4 + dir) % 4;
        else if (r == 7)
            ph = (ph + 4 - dir) % 4;
        lv = gray_ab(ph);
        if (r == 9)
            lv = 2'($urandom_range(0, 3));
        a = lv[1];
        b = lv[0];
    endtask

    // Mostly clean encoder motion with ticks, some loads and full resets.
    task automatic run_random(int n);
        int        r;
        bit        la;
        bit        lb;
        bit        ra;
        bit        rb;
        bit [31:0] setv;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            la = 1'($urandom_range(0, 1));
            lb = 1'($urandom_range(0, 1));
            ra = 1'($urandom_range(0, 1));
            rb = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       setv = 32'h7FFF_FFF0 + $urandom_range(0, 31);
                1:       setv = 32'hFFFF_FFF0 + $urandom_range(0, 31);
                default: setv = $urandom;
            endcase
            if (r < 65) begin
                move_side(l_phase, l_dir, la, lb);
                move_side(r_phase, r_dir, ra, rb);
                push_item(ACT_PIN, la, lb, ra, rb, 1'($urandom_range(0, 1)), setv);
            end else if (r < 93) begin
                push_item(ACT_TICK, la, lb, ra, rb, 1'($urandom_range(0, 1)), setv);
            end else if (r < 98) begin
                push_item(ACT_SET, la, lb, ra, rb, 1'($urandom_range(0, 1)), setv);
            end else begin
                push_item(ACT_RESET, la, lb, ra, rb, 1'($urandom_range(0, 1)), setv);
            end
        end
    endtask

    // Register write on the configuration channel; the block is idle here.
    task automatic write_reg(cfg_index_t idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_LEFT_INVERT:  inv_left = val[0];
            CFG_RIGHT_INVERT: inv_right = val[0];
            CFG_PERIOD_MS:    win_period = val[15:0];
            default:          vel_gain = val;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(bit linv, bit rinv, bit [15:0] period, bit [31:0] gain);
        write_reg(CFG_LEFT_INVERT, {31'd0, linv});
        write_reg(CFG_RIGHT_INVERT, {31'd0, rinv});
        write_reg(CFG_PERIOD_MS, {16'd0, period});
        write_reg(CFG_VEL_GAIN, gain);
    endtask

    // Hold the main sequence until every queued transaction has produced its result.
    task automatic wait_drained();
        while (pending_items.size() != 0 || have_cur || s_tvalid ||
               expected_odometry.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_EXTRA) @(posedge aclk);
    endtask

    // Sender: presents queued transactions after their gaps.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            have_cur = 1'b0;
        end else if (!s_tvalid || item_fire) begin
            if (!have_cur && pending_items.size() != 0) begin
                cur_item = pending_items.pop_front();
                have_cur = 1'b1;
                gap_left = cur_item.gap;
            end
            if (have_cur && gap_left == 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= cur_item.data;
                s_tuser <= cur_item.act;
                have_cur = 1'b0;
            end else begin
                s_tvalid <= 1'b0;
                if (have_cur)
                    gap_left--;
            end
        end
    end

    // Receiver: random stall after each result, plus the long hold on request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                rx_wait = LONG_HOLD;
            end else if (res_fire) begin
                rx_wait = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0);
        end
    end

    // Monitor: predicts on each input transaction and checks each result.
    always @(posedge aclk) begin : monitor
        odometry_t want;
        if (!aresetn) begin
            item_fire <= 1'b0;
            res_fire <= 1'b0;
        end else begin
            item_fire <= s_tvalid && s_tready;
            res_fire <= m_tvalid && m_tready;
            if (s_tvalid && s_tready)
                expected_odometry.push_back(advance_odometry(action_t'(s_tuser), s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_odometry.size() == 0) begin
                    $error("result transaction with no expected result pending");
                    errors++;
                end else begin
                    want = expected_odometry.pop_front();
                    check_field("left_count", want.left_count, m_tdata[31:0]);
                    check_field("right_count", want.right_count, m_tdata[63:32]);
                    check_field("left_velocity", want.left_vel, m_tdata[95:64]);
                    check_field("right_velocity", want.right_vel, m_tdata[127:96]);
                    check_field("velocity_updated", {31'd0, want.updated}, {31'd0, m_tuser});
                end
            end
        end
    end

    // Main sequence.
    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Unit gain, two-tick window, right side inverted.
        set_regs(1'b0, 1'b1, 16'd2, 32'h0001_0000);
        push_item(ACT_PIN, 0, 0, 0, 0, 0, 32'd0);
        push_item(ACT_PIN, 1, 0, 1, 0, 0, 32'd0);
        push_item(ACT_PIN, 1, 1, 1, 1, 0, 32'd0);
        push_item(ACT_PIN, 0, 1, 0, 1, 0, 32'd0);
        // Pin levels on a tick must not move the counts or the last A level.
        push_item(ACT_TICK, 1, 1, 1, 1, 1, 32'hFFFF_FFFF);
        push_item(ACT_TICK, 1, 0, 1, 0, 0, 32'd0);
        push_item(ACT_SET, 1, 1, 1, 1, 0, 32'h7FFF_FFFF);
        push_item(ACT_SET, 0, 0, 0, 0, 1, 32'h8000_0000);
        // The left count wraps across the signed upper limit; the right one steps up from the lower.
        push_item(ACT_PIN, 1, 0, 1, 1, 0, 32'd0);
        push_item(ACT_TICK, 0, 0, 0, 0, 0, 32'd0);
        push_item(ACT_TICK, 0, 0, 0, 0, 0, 32'd0);
        push_item(ACT_SET, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        push_item(ACT_RESET, 1, 0, 0, 1, 1, 32'h5555_AAAA);
        push_item(ACT_PIN, 0, 1, 0, 0, 0, 32'd0);
        run_random(90);
        wait_drained();

        // Largest gain with a zero period: every tick updates, and any nonzero window delta saturates.
        set_regs(1'b1, 1'b0, 16'd0, 32'hFFFF_FFFF);
        push_item(ACT_PIN, 1, 0, 1, 0, 0, 32'd0);
        push_item(ACT_PIN, 0, 0, 0, 1, 0, 32'd0);
        push_item(ACT_TICK, 0, 0, 0, 1, 0, 32'd0);
        push_item(ACT_TICK, 0, 0, 0, 1, 0, 32'd0);
        push_item(ACT_PIN, 1, 1, 1, 1, 0, 32'd0);
        push_item(ACT_TICK, 1, 1, 1, 1, 0, 32'd0);
        run_random(90);
        wait_drained();

        // Longest window and zero gain.
        set_regs(1'b1, 1'b1, 16'hFFFF, 32'd0);
        run_random(80);
        wait_drained();

        // Back-to-back traffic into a long receiver stall fills the pipeline.
        set_regs(1'b0, 1'b0, 16'd3, 32'h0003_243F);
        idle_on = 1'b0;
        hold_req++;
        run_random(60);
        wait_drained();
        idle_on = 1'b1;

        // Random settings, small windows so that updates come often.
        for (int ph = 0; ph < 4; ph++) begin
            set_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     16'($urandom_range(1, 6)),
                     (ph % 2 == 0) ? $urandom_range(0, 32'h0010_0000) : $urandom);
            idle_on = (ph != 2);
            run_random(80);
            wait_drained();
        end

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog.
    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/dqcv_pkg.sv
rtl/dqcv_lane.sv
rtl/dqcv_merge.sv
rtl/dual_quadrature_counter_velocity.sv
rtl/dqcv_checker.sv
bench/tb.sv
